// ===== hw/rtl/smpq_pkg.sv =====
// smpq_pkg: shared types, codes and sizes for the sorted min-priority queue
// used by smpq_cell and sorted_min_priority_queue; no dependencies
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int CAPACITY    = 256;
    localparam int WEIGHT_BITS = 32;
    localparam int SYMBOL_BITS = 8;
    localparam int HANDLE_BITS = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // action codes on the input tuser
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [SYMBOL_BITS-1:0] symbol;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   pop;
        t_entry fresh;
    } t_cmd;

    // what a cell shows its neighbours
    typedef struct packed {
        logic   valid;
        logic   go;
        t_entry entry;
    } t_link;

    // weight first, symbol breaks ties
    function automatic logic entry_lt(input t_entry a, input t_entry b);
        logic res;
        if (a.weight != b.weight) begin
            res = a.weight < b.weight;
        end else begin
            res = a.symbol < b.symbol;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/smpq_cell.sv =====
// smpq_cell: one slot of the sorted queue, compares against the broadcast
// entry and shifts towards either neighbour; depends on smpq_pkg
`timescale 1ns / 1ps

module smpq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head,
    input  smpq_pkg::t_cmd       i_cmd,
    input  smpq_pkg::t_link      i_left,
    input  smpq_pkg::t_link      i_right,
    output smpq_pkg::t_link      o_link
);

    logic            r_valid;
    logic            n_valid;
    smpq_pkg::t_entry r_entry;
    smpq_pkg::t_entry n_entry;
    logic            go;

    // go: the new word lands somewhere to the right of this slot
    // the head lets an equal word pass, later slots do not
    always_comb begin
        if (i_head) begin
            go = r_valid && !smpq_pkg::entry_lt(i_cmd.fresh, r_entry);
        end else begin
            go = r_valid && smpq_pkg::entry_lt(r_entry, i_cmd.fresh);
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_cmd.pop) begin
            n_valid = i_right.valid;
            n_entry = i_right.entry;
        end else if (i_cmd.ins) begin
            n_valid = r_valid || i_left.valid;
            if (!go) begin
                if (i_left.go) begin
                    n_entry = i_cmd.fresh;
                end else begin
                    n_entry = i_left.entry;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.valid = r_valid;
    assign o_link.go    = go;
    assign o_link.entry = r_entry;

endmodule

// ===== hw/rtl/sorted_min_priority_queue.sv =====
// sorted_min_priority_queue: top level, a row of smpq_cell slots kept in
// sorted order plus the entry count and output register; depends on smpq_pkg
`timescale 1ns / 1ps
//
// Usage: each word on the slave channel is one command. tuser selects
// enqueue (0) or dequeue (1); tdata carries the entry to enqueue. Each
// command gives exactly one word on the master channel: tuser holds the
// status (ok, dequeue from empty, enqueue into full), tdata the dequeued
// entry (zero for enqueue or failure) and the empty, single and full flags
// as they stand after the command.
// Every slot compares the broadcast entry in parallel and moves one place
// at most, so the result of an accepted command is registered and stands
// on the master channel in the cycle after it is accepted, and one command
// per cycle is sustained while the receiver keeps tready high. The rate is
// set by the per-slot compare and the single slot-to-slot shift.
// Reset empties the queue (slot valid bits and count cleared) and drops
// any pending result. When the receiver stalls the result stays in the
// output register and o_s_tready falls until it is taken.

module sorted_min_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // entry_weight[31:0], entry_symbol[39:32],
                                    // entry_handle[55:40]
    input  logic        i_s_tuser,  // action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,  // out_weight[31:0], out_symbol[39:32],
                                    // out_handle[55:40], now_empty[56],
                                    // now_single[57], now_full[58], zero above
    output logic [1:0]  o_m_tuser   // status
);

    localparam int N = smpq_pkg::CAPACITY;

    smpq_pkg::t_cmd   cmd;
    smpq_pkg::t_link  links [N];
    smpq_pkg::t_link  head_left;
    smpq_pkg::t_link  tail_right;
    smpq_pkg::t_entry zero_entry;

    logic [smpq_pkg::CNT_W-1:0] r_count;
    logic [smpq_pkg::CNT_W-1:0] n_count;
    logic                       r_out_valid;
    logic                       n_out_valid;
    smpq_pkg::t_status          r_status;
    smpq_pkg::t_status          n_status;
    smpq_pkg::t_entry           r_out;
    smpq_pkg::t_entry           n_out;
    logic                       r_empty, r_single, r_full;
    logic                       n_empty, n_single, n_full;

    logic accept;
    logic is_deq;
    logic q_empty;
    logic q_full;

    assign zero_entry = '0;
    assign head_left  = '{valid: 1'b1, go: 1'b1, entry: zero_entry};
    assign tail_right = '{valid: 1'b0, go: 1'b0, entry: zero_entry};

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_deq     = (i_s_tuser == smpq_pkg::ACT_DEQ);
    assign q_empty    = (r_count == '0);
    assign q_full     = (r_count == smpq_pkg::CNT_W'(N));

    assign cmd.ins          = accept && !is_deq && !q_full;
    assign cmd.pop          = accept && is_deq && !q_empty;
    assign cmd.fresh.weight = smpq_pkg::WEIGHT_BITS'(i_s_tdata[31:0]);
    assign cmd.fresh.symbol = i_s_tdata[39:32];
    assign cmd.fresh.handle = i_s_tdata[55:40];

    for (genvar i = 0; i < N; i++) begin : g_cell
        smpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_head  (i == 0),
            .i_cmd   (cmd),
            .i_left  ((i == 0) ? head_left : links[(i == 0) ? 0 : i - 1]),
            .i_right ((i == N - 1) ? tail_right : links[(i == N - 1) ? i : i + 1]),
            .o_link  (links[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (cmd.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_out       = r_out;
        n_empty     = r_empty;
        n_single    = r_single;
        n_full      = r_full;
        if (accept) begin
            n_out_valid = 1'b1;
            n_out       = zero_entry;
            if (is_deq) begin
                n_status = q_empty ? smpq_pkg::ST_EMPTY : smpq_pkg::ST_OK;
                if (!q_empty) begin
                    n_out = links[0].entry;
                end
            end else begin
                n_status = q_full ? smpq_pkg::ST_FULL : smpq_pkg::ST_OK;
            end
            n_empty  = (n_count == '0);
            n_single = (n_count == smpq_pkg::CNT_W'(1));
            n_full   = (n_count == smpq_pkg::CNT_W'(N));
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_out    <= n_out;
        r_empty  <= n_empty;
        r_single <= n_single;
        r_full   <= n_full;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {5'd0, r_full, r_single, r_empty, r_out.handle, r_out.symbol,
                         32'(r_out.weight)};

endmodule
